// ===== hw/rtl/pvs_pkg.sv =====
`timescale 1ns / 1ps
package pvs_pkg;
    localparam int FRAMES_DEF = 4096;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAME_W = 12;
    localparam int STAMP_W = 32;
    localparam int FREE_W = 13;

    typedef enum logic [1:0] {
        CMD_ACCESS  = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_VICTIM  = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_LFU = 2'd1;
    localparam logic [1:0] POL_MFU = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] frame;
        logic [31:0] stamp;
    } req_t;
endpackage

// ===== hw/rtl/pvs_ram.sv =====
`timescale 1ns / 1ps
module pvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/pvs_front.sv =====
`timescale 1ns / 1ps
module pvs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,
    output logic             q_valid,
    input  logic             q_pop,
    output pvs_pkg::req_t    q_data
);
    pvs_pkg::req_t buf_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push;

    assign s_tready = cnt_reg != 2'd2;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_data   = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= '{cmd: s_tdata[1:0], frame: s_tdata[13:2],
                                 stamp: s_tdata[45:14]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== hw/rtl/pvs_back.sv =====
`timescale 1ns / 1ps
module pvs_back #(
    parameter int FRAMES = pvs_pkg::FRAMES_DEF,
    parameter int COUNT_BITS = pvs_pkg::COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    policy,
    input  logic          q_valid,
    output logic          q_pop,
    input  pvs_pkg::req_t q_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata
);
    localparam int AW = $clog2(FRAMES);
    localparam int EW = 1 + 32 + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    pvs_pkg::state_t state_reg, state_next;
    logic [AW:0]     idx_reg, idx_next;
    logic [AW:0]     best_reg, best_next;
    logic            found_reg, found_next;
    logic [31:0]     bl_reg, bl_next;
    logic [COUNT_BITS-1:0] bc_reg, bc_next;
    logic            rdv_reg, rdv_next;
    logic [AW-1:0]   rdi_reg, rdi_next;
    logic [pvs_pkg::FREE_W-1:0] free_reg, free_next;
    logic [pvs_pkg::FRAME_W-1:0] res_reg, res_next;
    logic            ok_reg, ok_next;
    pvs_pkg::req_t   cur_reg, cur_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;
    logic            r_occ;
    logic [31:0]     r_lu;
    logic [COUNT_BITS-1:0] r_uc;
    logic            in_range, better;

    assign r_occ = rdata[EW-1];
    assign r_lu  = rdata[EW-2:COUNT_BITS];
    assign r_uc  = rdata[COUNT_BITS-1:0];
    assign in_range = {{(32-pvs_pkg::FRAME_W){1'b0}}, cur_reg.frame} < 32'(FRAMES);

    pvs_ram #(.WIDTH(EW), .DEPTH(FRAMES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign m_tvalid = state_reg == pvs_pkg::ST_OUT;
    assign m_tdata  = {6'd0, free_reg, ok_reg, res_reg};

    always_comb
    begin
        case (policy)
            pvs_pkg::POL_LFU: better = r_uc < bc_reg;
            pvs_pkg::POL_MFU: better = r_uc > bc_reg;
            default:          better = r_lu < bl_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        found_next = found_reg;
        bl_next    = bl_reg;
        bc_next    = bc_reg;
        rdv_next   = 1'b0;
        rdi_next   = rdi_reg;
        free_next  = free_reg;
        res_next   = res_reg;
        ok_next    = ok_reg;
        cur_next   = cur_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wdata      = '0;
        raddr      = idx_reg[AW-1:0];
        case (state_reg)
            pvs_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (AW+1)'(FRAMES - 1))
                begin
                    state_next = pvs_pkg::ST_IDLE;
                end
            end
            pvs_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cur_next  = q_data;
                    res_next  = q_data.frame;
                    ok_next   = 1'b0;
                    idx_next  = '0;
                    found_next = 1'b0;
                    best_next = '0;
                    if (q_data.cmd == pvs_pkg::CMD_ALLOC
                        || q_data.cmd == pvs_pkg::CMD_VICTIM)
                    begin
                        res_next   = '0;
                        state_next = pvs_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = pvs_pkg::ST_ACC_RD;
                    end
                end
            end
            pvs_pkg::ST_ACC_RD:
            begin
                raddr = cur_reg.frame[AW-1:0];
                state_next = in_range ? pvs_pkg::ST_ACC_WR : pvs_pkg::ST_OUT;
            end
            pvs_pkg::ST_ACC_WR:
            begin
                waddr = cur_reg.frame[AW-1:0];
                if (cur_reg.cmd == pvs_pkg::CMD_ACCESS)
                begin
                    we = 1'b1;
                    wdata = {r_occ, cur_reg.stamp, (r_uc == CMAX) ? r_uc : r_uc + 1'b1};
                    ok_next = 1'b1;
                end
                else if (r_occ)
                begin
                    we = 1'b1;
                    wdata = {1'b0, r_lu, r_uc};
                    ok_next = 1'b1;
                    free_next = free_reg + 1'b1;
                end
                state_next = pvs_pkg::ST_OUT;
            end
            pvs_pkg::ST_SCAN:
            begin
                if (idx_reg != (AW+1)'(FRAMES))
                begin
                    rdv_next = 1'b1;
                    rdi_next = idx_reg[AW-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    if (cur_reg.cmd == pvs_pkg::CMD_ALLOC)
                    begin
                        if (!r_occ)
                        begin
                            we = 1'b1;
                            waddr = rdi_reg;
                            wdata = {1'b1, r_lu, r_uc};
                            res_next = pvs_pkg::FRAME_W'(rdi_reg);
                            ok_next = 1'b1;
                            free_next = free_reg - 1'b1;
                            rdv_next = 1'b0;
                            state_next = pvs_pkg::ST_OUT;
                        end
                    end
                    else if (r_occ && (!found_reg || better))
                    begin
                        found_next = 1'b1;
                        best_next = {1'b0, rdi_reg};
                        bl_next = r_lu;
                        bc_next = r_uc;
                    end
                end
                if (idx_reg == (AW+1)'(FRAMES) && !rdv_reg)
                begin
                    state_next = pvs_pkg::ST_FINISH;
                end
            end
            pvs_pkg::ST_FINISH:
            begin
                raddr = best_reg[AW-1:0];
                if (cur_reg.cmd == pvs_pkg::CMD_VICTIM && found_reg)
                begin
                    res_next = pvs_pkg::FRAME_W'(best_reg[AW-1:0]);
                    ok_next = 1'b1;
                    if (policy == pvs_pkg::POL_LFU || policy == pvs_pkg::POL_MFU)
                    begin
                        we = 1'b1;
                        waddr = best_reg[AW-1:0];
                        wdata = {1'b1, bl_reg, {COUNT_BITS{1'b0}}};
                    end
                end
                state_next = pvs_pkg::ST_OUT;
            end
            pvs_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = pvs_pkg::ST_IDLE;
                end
            end
            default: state_next = pvs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        bl_reg   <= bl_next;
        bc_reg   <= bc_next;
        rdi_reg  <= rdi_next;
        res_reg  <= res_next;
        ok_reg   <= ok_next;
        cur_reg  <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pvs_pkg::ST_CLEAR;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            rdv_reg   <= 1'b0;
            free_reg  <= pvs_pkg::FREE_W'(FRAMES);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            rdv_reg   <= rdv_next;
            free_reg  <= free_next;
        end
    end
endmodule

// ===== hw/rtl/page_victim_selector_unit.sv =====
`timescale 1ns / 1ps
// Page frame manager with LRU / LFU / MFU victim choice.
// s_* channel carries commands; m_* channel returns one result per command.
// cfg_* channel writes the policy register; write only while idle.
// A two-entry queue buffers commands while the back end works.
// Access and release: the frame entry is read, then written back (skipped for an out-of-range frame).
// Allocate: the scan stops at the first free frame.
// Victim: the scan covers every frame, one frame RAM read per cycle.
// After reset a clearing pass zeroes the frame RAM; up to two commands
// queue but none starts before it ends, policy writes are taken at once.
// While m_tready is low the result holds and up to two commands still queue.
module page_victim_selector_unit #(
    parameter int FRAMES = pvs_pkg::FRAMES_DEF,
    parameter int COUNT_BITS = pvs_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cmd[1:0], frame_in[13:2], stamp[45:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_frame[11:0], ok[12], free_frames[25:13]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    logic          q_valid, q_pop;
    pvs_pkg::req_t q_data;
    logic [1:0]    policy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= pvs_pkg::POL_LRU;
        end
        else if (cfg_valid)
        begin
            policy_reg <= cfg_data;
        end
    end

    pvs_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    pvs_back #(.FRAMES(FRAMES), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .policy(policy_reg), .q_valid(q_valid),
        .q_pop(q_pop), .q_data(q_data), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule
